>>> rtl/core/pms_pkg.sv
// shared types and constants for the prefix match suggester
package pms_pkg;

  localparam int MODE_W  = 1;
  localparam int IDX_W   = 5;
  localparam int CPOS_W  = 5;
  localparam int CHAR_W  = 8;
  localparam int LEN_W   = 6;
  localparam int CMP_W   = 7;

  localparam logic [MODE_W-1:0] MODE_LOAD = 1'b0;
  localparam logic [MODE_W-1:0] MODE_KEY  = 1'b1;

  localparam logic [CHAR_W-1:0] ENTER_CODE = 8'd13;
  localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'd0;

  localparam logic [LEN_W-1:0] COUNT_MAX   = 6'd63;
  // slot number of the final result a keystroke may deliver
  localparam logic [LEN_W-1:0] RESULT_LAST = 6'd31;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] match_index;
    logic             found;
    logic             last;
    logic [LEN_W-1:0] prefix_length;
  } result_t;

endpackage

>>> rtl/core/pms_dict_mem.sv
// dictionary byte store, one write and one registered read port
module pms_dict_mem #(
  parameter int ADDR_W = 10,
  parameter int DEPTH  = 1024
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [ADDR_W-1:0]             waddr,
  input  logic [pms_pkg::CHAR_W-1:0]    wdata,
  input  logic                          re,
  input  logic [ADDR_W-1:0]             raddr,
  output logic [pms_pkg::CHAR_W-1:0]    rdata
);

  logic [pms_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/pms_ctrl.sv
// sequencer: clearing pass, loads, keystroke scan over the store and result walk
module pms_ctrl #(
  parameter int NUM_WORDS = 32,
  parameter int WORD_LEN  = 32,
  parameter int WORD_W    = 5,
  parameter int POS_W     = 5,
  parameter int ADDR_W    = 10,
  parameter int DEPTH     = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [pms_pkg::MODE_W-1:0]   mode,
  input  logic [pms_pkg::IDX_W-1:0]    word_index,
  input  logic [pms_pkg::CPOS_W-1:0]   char_position,
  input  logic [pms_pkg::CHAR_W-1:0]   char_value,
  output logic                         mem_we,
  output logic [ADDR_W-1:0]            mem_waddr,
  output logic [pms_pkg::CHAR_W-1:0]   mem_wdata,
  output logic                         mem_re,
  output logic [ADDR_W-1:0]            mem_raddr,
  input  logic [pms_pkg::CHAR_W-1:0]   mem_rdata,
  input  logic                         out_free,
  output logic                         res_push,
  output pms_pkg::result_t             res
);

  pms_pkg::state_t             state, state_next;
  logic [ADDR_W-1:0]           clr_addr;
  logic [WORD_W:0]             scan_cnt;
  logic [pms_pkg::CHAR_W-1:0]  key_char;
  logic [POS_W-1:0]            pos;
  logic                        pos_ok;
  logic [pms_pkg::LEN_W-1:0]   prefix_count;
  logic [NUM_WORDS-1:0]        mask, mask_next;
  logic [NUM_WORDS-1:0]        pending, pending_clr;
  logic [pms_pkg::LEN_W-1:0]   emit_cnt;

  logic                        accept;
  logic                        is_load, is_enter, is_key;
  logic                        load_in_range;
  logic                        clr_done, scan_done;
  logic [WORD_W-1:0]           prv;
  logic                        keep;
  logic [WORD_W-1:0]           low;
  logic                        any;

  assign accept    = item_valid && item_ready;
  assign is_load   = (mode == pms_pkg::MODE_LOAD);
  assign is_enter  = !is_load && (char_value == pms_pkg::ENTER_CODE);
  assign is_key    = !is_load && !is_enter;
  assign load_in_range =
      (pms_pkg::CMP_W'(word_index) < pms_pkg::CMP_W'(NUM_WORDS)) &&
      (pms_pkg::CMP_W'(char_position) < pms_pkg::CMP_W'(WORD_LEN));
  assign clr_done  = (clr_addr == ADDR_W'(DEPTH - 1));
  assign scan_done = (scan_cnt == (WORD_W + 1)'(NUM_WORDS));

  // data on the read port belongs to the word issued in the previous cycle
  assign prv  = scan_cnt[WORD_W-1:0] - 1'b1;
  assign keep = pos_ok && (mem_rdata != pms_pkg::NUL_CHAR) && (mem_rdata == key_char);

  always_comb begin
    mask_next = mask;
    if (state == pms_pkg::ST_SCAN && scan_cnt != '0 && !keep) begin
      mask_next[prv] = 1'b0;
    end
  end

  // lowest pending word
  always_comb begin
    low = '0;
    for (int i = NUM_WORDS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        low = WORD_W'(i);
      end
    end
  end

  assign any         = |pending;
  assign pending_clr = pending & ~(NUM_WORDS'(1) << low);

  always_comb begin
    state_next = state;
    unique case (state)
      pms_pkg::ST_CLEAR: begin
        if (clr_done) state_next = pms_pkg::ST_IDLE;
      end
      pms_pkg::ST_IDLE: begin
        if (accept && is_key) state_next = pms_pkg::ST_SCAN;
      end
      pms_pkg::ST_SCAN: begin
        if (scan_done) state_next = pms_pkg::ST_EMIT;
      end
      pms_pkg::ST_EMIT: begin
        if (out_free && res.last) state_next = pms_pkg::ST_IDLE;
      end
      default: state_next = pms_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = {WORD_W'(word_index), POS_W'(char_position)};
    mem_wdata  = char_value;
    mem_re     = 1'b0;
    mem_raddr  = {scan_cnt[WORD_W-1:0], pos};
    res_push   = 1'b0;
    res.match_index   = pms_pkg::IDX_W'(low);
    res.found         = 1'b1;
    res.last          = (pending_clr == '0) || (emit_cnt == pms_pkg::RESULT_LAST);
    res.prefix_length = prefix_count;
    if (!any) begin
      res.match_index = '0;
      res.found       = 1'b0;
      res.last        = 1'b1;
    end
    unique case (state)
      pms_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = pms_pkg::NUL_CHAR;
      end
      pms_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        mem_we     = item_valid && is_load && load_in_range;
      end
      pms_pkg::ST_SCAN: begin
        mem_re = (scan_cnt < (WORD_W + 1)'(NUM_WORDS));
      end
      pms_pkg::ST_EMIT: begin
        res_push = out_free;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pms_pkg::ST_CLEAR;
      clr_addr     <= '0;
      mask         <= '1;
      prefix_count <= '0;
      scan_cnt     <= '0;
      emit_cnt     <= '0;
    end else begin
      state <= state_next;
      if (state == pms_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (accept) begin
        if (is_key) begin
          key_char <= char_value;
          pos      <= POS_W'(prefix_count);
          pos_ok   <= (pms_pkg::CMP_W'(prefix_count) < pms_pkg::CMP_W'(WORD_LEN));
          scan_cnt <= '0;
          if (prefix_count != pms_pkg::COUNT_MAX) begin
            prefix_count <= prefix_count + 1'b1;
          end
        end else begin
          // loads and enter clear the prefix
          mask         <= '1;
          prefix_count <= '0;
        end
      end
      if (state == pms_pkg::ST_SCAN) begin
        mask     <= mask_next;
        scan_cnt <= scan_cnt + 1'b1;
        if (scan_done) begin
          pending  <= mask_next;
          emit_cnt <= '0;
        end
      end
      if (res_push) begin
        pending  <= pending_clr;
        emit_cnt <= emit_cnt + 1'b1;
      end
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
      (state == pms_pkg::ST_SCAN || state == pms_pkg::ST_EMIT) |-> !mem_we)
    else $error("store written during a keystroke");

  a_not_found_is_last: assert property (@(posedge clk) disable iff (rst)
      (res_push && !res.found) |-> (res.last && emit_cnt == '0))
    else $error("not-found result is not the only result");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (rst)
      (res_push && res.last) |=> (state == pms_pkg::ST_IDLE))
    else $error("walk continues after last result");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
      res_push |-> (emit_cnt <= pms_pkg::RESULT_LAST))
    else $error("too many results for one keystroke");

endmodule

>>> rtl/core/pms_out.sv
// output register stage for results
module pms_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  pms_pkg::result_t            res,
  output logic                        out_free,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [pms_pkg::IDX_W-1:0]   match_index,
  output logic                        found,
  output logic                        last,
  output logic [pms_pkg::LEN_W-1:0]   prefix_length
);

  pms_pkg::result_t held;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && push) begin
      held <= res;
    end
  end

  assign match_index   = held.match_index;
  assign found         = held.found;
  assign last          = held.last;
  assign prefix_length = held.prefix_length;

endmodule

>>> rtl/core/prefix_match_suggester_core.sv
// prefix match suggester: a keystroke scans the store, one read a word
// results are walked out after the scan, one result a cycle unless result_ready holds the output
// a keystroke occupies the sequencer through scan and walk; a load or enter is taken in idle
// the single read port of the byte store sets the scan length
// after reset a clearing pass zeroes all NUM_WORDS*2^clog2(WORD_LEN) store bytes (1024)
// no request is taken during the clearing pass; prefix resets to empty
module prefix_match_suggester_core #(
  parameter int NUM_WORDS = 32,
  parameter int WORD_LEN  = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [pms_pkg::MODE_W-1:0]  mode,
  input  logic [pms_pkg::IDX_W-1:0]   word_index,
  input  logic [pms_pkg::CPOS_W-1:0]  char_position,
  input  logic [pms_pkg::CHAR_W-1:0]  char_value,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [pms_pkg::IDX_W-1:0]   match_index,
  output logic                        found,
  output logic                        last,
  output logic [pms_pkg::LEN_W-1:0]   prefix_length
);

  localparam int WORD_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int POS_W  = $clog2(WORD_LEN);
  localparam int ADDR_W = WORD_W + POS_W;
  localparam int DEPTH  = NUM_WORDS * (2 ** POS_W);

  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_waddr;
  logic [pms_pkg::CHAR_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [ADDR_W-1:0]           mem_raddr;
  logic [pms_pkg::CHAR_W-1:0]  mem_rdata;
  logic                        out_free;
  logic                        res_push;
  pms_pkg::result_t            res;

  pms_dict_mem #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  pms_ctrl #(
    .NUM_WORDS (NUM_WORDS),
    .WORD_LEN  (WORD_LEN),
    .WORD_W    (WORD_W),
    .POS_W     (POS_W),
    .ADDR_W    (ADDR_W),
    .DEPTH     (DEPTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .mode          (mode),
    .word_index    (word_index),
    .char_position (char_position),
    .char_value    (char_value),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata),
    .out_free      (out_free),
    .res_push      (res_push),
    .res           (res)
  );

  pms_out u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (res_push),
    .res           (res),
    .out_free      (out_free),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .match_index   (match_index),
    .found         (found),
    .last          (last),
    .prefix_length (prefix_length)
  );

endmodule
